// ===== rtl/btk_pkg.sv =====
package btk_pkg;

  localparam int BTK_HEAP_DEPTH = 64;
  localparam int FILL_W = 7;
  localparam int KEY_W = 16;
  localparam int CODE_W = 64;
  localparam int EQ_W = 32;
  localparam logic [FILL_W-1:0] BTK_KEEP_RESET = 7'd64;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_POP    = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_DRAIN  = 2'd3
  } cmd_t;

  typedef logic [FILL_W-1:0] limit_t;

  typedef struct packed {
    cmd_t                    cmd;
    logic [KEY_W-1:0]        draw_key;
    logic [CODE_W-1:0]       leave_code;
    logic [CODE_W-1:0]       exchanged_code;
    logic signed [EQ_W-1:0]  equity_value;
  } in_beat_t;

  typedef struct packed {
    logic [KEY_W-1:0]        out_key;
    logic [CODE_W-1:0]       out_leave;
    logic [CODE_W-1:0]       out_exchanged;
    logic signed [EQ_W-1:0]  out_equity;
    logic                    entry_valid;
    logic                    heap_empty;
    logic [FILL_W-1:0]       entry_count;
    logic                    last_result;
  } out_beat_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [CODE_W-1:0] leave;
    logic [CODE_W-1:0] exch;
    logic [EQ_W-1:0]   equity;
  } entry_t;

  typedef struct packed {
    logic go;
    logic take_b;
  } sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SU_RD,
    S_SU_CMP,
    S_UP_END,
    S_POP_RD,
    S_POP_CMP,
    S_SD_RD,
    S_SD_CMP,
    S_DN_END,
    S_RES_RD,
    S_RES_LD,
    S_ACK
  } state_t;

endpackage

// ===== rtl/btk_chan_if.sv =====
interface btk_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/btk_ram.sv =====
module btk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== rtl/btk_cmp.sv =====
module btk_cmp
  import btk_pkg::*;
(
  input  logic             up_mode,
  input  logic [KEY_W-1:0] mov_key,
  input  logic [KEY_W-1:0] a_key,
  input  logic [KEY_W-1:0] b_key,
  input  logic             a_ok,
  input  logic             b_ok,
  output sel_t             sel
);

  logic             pick_a;
  logic [KEY_W-1:0] min_key;
  logic             pick_b;

  always_comb begin
    pick_a  = a_ok && (a_key < mov_key);
    min_key = pick_a ? a_key : mov_key;
    pick_b  = b_ok && (b_key < min_key);
    if (up_mode) begin
      sel.go     = a_key > mov_key;
      sel.take_b = 1'b0;
    end else begin
      sel.go     = pick_a || pick_b;
      sel.take_b = pick_b;
    end
  end

endmodule

// ===== rtl/bounded_top_k_min_heap.sv =====
// channel  dir  payload                                        beat when
// in_ch    in   cmd .. equity_value (in_beat_t)                valid && ready
// out_ch   out  out_key .. last_result (out_beat_t)            valid && ready
// cfg_ch   in   keep_limit (7 bits)                            valid && ready
//
// One command at a time; in_ch.ready is high only while idle.
// Sift loop per compared level: RAM read, then compare and write. An insert sifts up;
// a pop sifts down; an evicting insert sifts up, then down. Drain: one pop per entry,
// then one result beat per entry, each read out of the RAM.
// Synchronous active-low reset empties the heap and sets keep_limit to 64.
// A result waits in the output register; a stalled out_ch holds the block.
module bounded_top_k_min_heap
  import btk_pkg::*;
#(
  parameter int HEAP_DEPTH = BTK_HEAP_DEPTH
) (
  input logic        clk,
  input logic        rst_n,
  btk_chan_if.sink   in_ch,
  btk_chan_if.source out_ch,
  btk_chan_if.sink   cfg_ch
);

  localparam int SLOTS = HEAP_DEPTH + 1;
  localparam int ADDR_W = $clog2(SLOTS);
  localparam int ENTRY_W = $bits(entry_t);
  localparam logic [FILL_W-1:0] DEPTH_L = FILL_W'(HEAP_DEPTH);

  state_t            state_r, state_nxt;
  cmd_t              op_r, op_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [FILL_W-1:0] idx_r, idx_nxt;
  logic [FILL_W-1:0] cnt_r, cnt_nxt;
  logic [FILL_W-1:0] drain_r, drain_nxt;
  logic [FILL_W-1:0] keep_r;
  entry_t            mov_r, mov_nxt;
  out_beat_t         out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              we;
  logic [ADDR_W-1:0] waddr, ra_addr, rb_addr;
  entry_t            wdata;
  logic [ENTRY_W-1:0] ra_raw, rb_raw;
  entry_t            ra, rb;

  logic [FILL_W-1:0] cap;
  logic [FILL_W-1:0] parent;
  logic [FILL_W:0]   lch, rch;
  logic              lch_ok, rch_ok;
  logic [FILL_W-1:0] fill_dec;
  logic [FILL_W-1:0] res_addr;
  logic              last_drain;
  logic              out_free;
  logic              in_fire;
  state_t            pop_done;
  sel_t              sel;

  assign ra = entry_t'(ra_raw);
  assign rb = entry_t'(rb_raw);

  btk_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (ENTRY_W'(wdata)),
    .raddr_a (ra_addr),
    .rdata_a (ra_raw),
    .raddr_b (rb_addr),
    .rdata_b (rb_raw)
  );

  btk_cmp u_cmp (
    .up_mode (state_r == S_SU_CMP),
    .mov_key (mov_r.key),
    .a_key   (ra.key),
    .b_key   (rb.key),
    .a_ok    ((state_r == S_SU_CMP) || lch_ok),
    .b_ok    (rch_ok),
    .sel     (sel)
  );

  always_comb begin
    if (keep_r == '0) begin
      cap = FILL_W'(1);
    end else if (keep_r > DEPTH_L) begin
      cap = DEPTH_L;
    end else begin
      cap = keep_r;
    end
  end

  assign parent     = (idx_r - 1'b1) >> 1;
  assign lch        = {idx_r, 1'b1};
  assign rch        = lch + 1'b1;
  assign lch_ok     = lch < {1'b0, fill_r};
  assign rch_ok     = rch < {1'b0, fill_r};
  assign fill_dec   = fill_r - 1'b1;
  assign res_addr   = (op_r == CMD_POP) ? fill_r : drain_r;
  assign last_drain = drain_r == (cnt_r - 1'b1);
  assign out_free   = !out_valid_r || out_ch.ready;
  assign in_fire    = in_ch.valid && in_ch.ready;

  assign in_ch.ready  = state_r == S_IDLE;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  always_comb begin
    case (op_r)
      CMD_POP:   pop_done = S_RES_RD;
      CMD_DRAIN: pop_done = S_POP_RD;
      default:   pop_done = S_ACK;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_ch.data.cmd)
            CMD_INSERT: state_nxt = (fill_r == '0) ? S_UP_END : S_SU_RD;
            CMD_POP:    state_nxt = (fill_r == '0) ? S_ACK : S_POP_RD;
            CMD_CLEAR:  state_nxt = S_ACK;
            default:    state_nxt = (fill_r == '0) ? S_ACK : S_POP_RD;
          endcase
        end
      end
      S_SU_RD:   state_nxt = S_SU_CMP;
      S_SU_CMP: begin
        if (sel.go && parent != '0) begin
          state_nxt = S_SU_RD;
        end else begin
          state_nxt = S_UP_END;
        end
      end
      S_UP_END:  state_nxt = (fill_r > cap) ? S_POP_RD : S_ACK;
      S_POP_RD:  state_nxt = S_POP_CMP;
      S_POP_CMP: begin
        if (fill_dec != '0) begin
          state_nxt = S_SD_RD;
        end else if (op_r == CMD_DRAIN) begin
          state_nxt = S_RES_RD;
        end else begin
          state_nxt = pop_done;
        end
      end
      S_SD_RD:   state_nxt = lch_ok ? S_SD_CMP : S_DN_END;
      S_SD_CMP:  state_nxt = sel.go ? S_SD_RD : S_DN_END;
      S_DN_END:  state_nxt = pop_done;
      S_RES_RD:  state_nxt = S_RES_LD;
      S_RES_LD: begin
        if (out_free) begin
          state_nxt = (op_r == CMD_POP || last_drain) ? S_IDLE : S_RES_RD;
        end
      end
      S_ACK: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    op_nxt        = op_r;
    fill_nxt      = fill_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    drain_nxt     = drain_r;
    mov_nxt       = mov_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    we            = 1'b0;
    waddr         = idx_r[ADDR_W-1:0];
    wdata         = mov_r;
    ra_addr       = '0;
    rb_addr       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt       = in_ch.data.cmd;
          idx_nxt      = fill_r;
          mov_nxt.key    = in_ch.data.draw_key;
          mov_nxt.leave  = in_ch.data.leave_code;
          mov_nxt.exch   = in_ch.data.exchanged_code;
          mov_nxt.equity = in_ch.data.equity_value;
          case (in_ch.data.cmd)
            CMD_INSERT: fill_nxt = fill_r + 1'b1;
            CMD_CLEAR:  fill_nxt = '0;
            CMD_DRAIN: begin
              cnt_nxt   = fill_r;
              drain_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      S_SU_RD: ra_addr = parent[ADDR_W-1:0];
      S_SU_CMP: begin
        if (sel.go) begin
          we      = 1'b1;
          wdata   = ra;
          idx_nxt = parent;
        end
      end
      S_UP_END: we = 1'b1;
      S_POP_RD: begin
        ra_addr = '0;
        rb_addr = fill_dec[ADDR_W-1:0];
      end
      S_POP_CMP: begin
        we       = 1'b1;
        waddr    = fill_dec[ADDR_W-1:0];
        wdata    = ra;
        mov_nxt  = rb;
        fill_nxt = fill_dec;
        idx_nxt  = '0;
      end
      S_SD_RD: begin
        ra_addr = lch[ADDR_W-1:0];
        rb_addr = rch[ADDR_W-1:0];
      end
      S_SD_CMP: begin
        if (sel.go) begin
          we      = 1'b1;
          wdata   = sel.take_b ? rb : ra;
          idx_nxt = sel.take_b ? rch[FILL_W-1:0] : lch[FILL_W-1:0];
        end
      end
      S_DN_END: we = 1'b1;
      S_RES_RD: ra_addr = res_addr[ADDR_W-1:0];
      S_RES_LD: begin
        ra_addr = res_addr[ADDR_W-1:0];
        if (out_free) begin
          out_nxt.out_key       = ra.key;
          out_nxt.out_leave     = ra.leave;
          out_nxt.out_exchanged = ra.exch;
          out_nxt.out_equity    = ra.equity;
          out_nxt.entry_valid   = 1'b1;
          out_nxt.heap_empty    = 1'b0;
          out_nxt.entry_count   = fill_r;
          out_nxt.last_result   = (op_r == CMD_POP) || last_drain;
          out_valid_nxt         = 1'b1;
          drain_nxt             = drain_r + 1'b1;
        end
      end
      S_ACK: begin
        if (out_free) begin
          out_nxt.out_key       = '0;
          out_nxt.out_leave     = '0;
          out_nxt.out_exchanged = '0;
          out_nxt.out_equity    = '0;
          out_nxt.entry_valid   = 1'b0;
          out_nxt.heap_empty    = (op_r == CMD_POP) || (op_r == CMD_DRAIN);
          out_nxt.entry_count   = fill_r;
          out_nxt.last_result   = 1'b1;
          out_valid_nxt         = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= CMD_INSERT;
      fill_r      <= '0;
      idx_r       <= '0;
      cnt_r       <= '0;
      drain_r     <= '0;
      out_valid_r <= 1'b0;
      keep_r      <= BTK_KEEP_RESET;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      fill_r      <= fill_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      drain_r     <= drain_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        keep_r <= cfg_ch.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    mov_r <= mov_nxt;
    out_r <= out_nxt;
  end

`ifndef SYNTH
  a_fill_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (fill_r <= DEPTH_L))
    else $error("fill above heap depth while idle");

  a_sift_up_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SU_CMP && sel.go) |=> (idx_r < $past(idx_r)))
    else $error("sift-up did not move toward the root");

  a_sift_down_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SD_CMP && sel.go) |=> (idx_r > $past(idx_r)))
    else $error("sift-down did not move toward the leaves");

  a_drain_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.entry_valid && !out_r.last_result)
      |-> (out_r.entry_count == '0))
    else $error("non-final drain beat with nonzero count");
`endif

endmodule

// ===== sim/bounded_top_k_min_heap_tb.sv =====
module bounded_top_k_min_heap_tb;
  import btk_pkg::*;

  class topk_heap_tracker;
    entry_t    slot_q [0:BTK_HEAP_DEPTH];
    int        fill;
    limit_t    keep;
    out_beat_t due_beats[$];
    int        errors;
    int        beats_ok;
    int        n_cmd;
    int        n_insert;
    int        n_pop;
    int        n_clear;
    int        n_drain;
    int        n_empty;
    int        n_evict;
    int        deepest;
    int        peak_fill;

    function new();
      fill = 0;
      keep = BTK_KEEP_RESET;
      foreach (slot_q[i]) slot_q[i] = '0;
    endfunction

    function void set_keep_limit(limit_t v);
      keep = v;
    endfunction

    function void swap_slots(int a, int b);
      entry_t t;
      t = slot_q[a];
      slot_q[a] = slot_q[b];
      slot_q[b] = t;
    endfunction

    function void sift_up(int idx);
      int par;
      while (idx > 0) begin
        par = (idx - 1) / 2;
        if (slot_q[par].key > slot_q[idx].key) begin
          swap_slots(par, idx);
          idx = par;
        end else begin
          break;
        end
      end
    endfunction

    function void sift_down(int idx);
      int l;
      int r;
      int m;
      while (idx < fill) begin
        l = idx * 2 + 1;
        r = idx * 2 + 2;
        m = idx;
        if (l < fill && slot_q[l].key < slot_q[idx].key) m = l;
        if (r < fill && slot_q[r].key < slot_q[m].key) m = r;
        if (m == idx) break;
        swap_slots(m, idx);
        idx = m;
      end
    endfunction

    // removed minimum ends up in slot fill
    function void pop_min();
      if (fill == 0) return;
      fill--;
      if (fill == 0) return;
      swap_slots(0, fill);
      sift_down(0);
    endfunction

    function void push_result(int slot, bit valid, bit empty, bit last);
      out_beat_t b;
      b = '0;
      if (valid) begin
        b.out_key = slot_q[slot].key;
        b.out_leave = slot_q[slot].leave;
        b.out_exchanged = slot_q[slot].exch;
        b.out_equity = slot_q[slot].equity;
      end
      b.entry_valid = valid;
      b.heap_empty = empty;
      b.entry_count = FILL_W'(fill);
      b.last_result = last;
      due_beats.push_back(b);
    endfunction

    function void take_command(in_beat_t c);
      int cap;
      int s;
      int n;
      n_cmd++;
      case (c.cmd)
        CMD_INSERT: begin
          n_insert++;
          cap = int'(keep);
          if (cap < 1) cap = 1;
          if (cap > BTK_HEAP_DEPTH) cap = BTK_HEAP_DEPTH;
          s = (fill > BTK_HEAP_DEPTH) ? BTK_HEAP_DEPTH : fill;
          slot_q[s].key = c.draw_key;
          slot_q[s].leave = c.leave_code;
          slot_q[s].exch = c.exchanged_code;
          slot_q[s].equity = c.equity_value;
          sift_up(s);
          fill = s + 1;
          if (fill > cap) begin
            pop_min();
            n_evict++;
          end
          if (fill > peak_fill) peak_fill = fill;
          push_result(0, 1'b0, 1'b0, 1'b1);
        end
        CMD_POP: begin
          n_pop++;
          if (fill == 0) begin
            n_empty++;
            push_result(0, 1'b0, 1'b1, 1'b1);
          end else begin
            pop_min();
            push_result(fill, 1'b1, 1'b0, 1'b1);
          end
        end
        CMD_CLEAR: begin
          n_clear++;
          fill = 0;
          push_result(0, 1'b0, 1'b0, 1'b1);
        end
        default: begin
          n_drain++;
          n = fill;
          if (n == 0) begin
            n_empty++;
            push_result(0, 1'b0, 1'b1, 1'b1);
          end else begin
            while (fill > 0) pop_min();
            for (int i = 0; i < n; i++) push_result(i, 1'b1, 1'b0, i == n - 1);
            if (n > deepest) deepest = n;
          end
        end
      endcase
    endfunction

    function void field_eq(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_beat(out_beat_t got);
      out_beat_t want;
      if (due_beats.size() == 0) begin
        $error("result beat with nothing pending: key %0h count %0d",
               got.out_key, got.entry_count);
        errors++;
        return;
      end
      want = due_beats.pop_front();
      beats_ok++;
      field_eq("out_key", 64'(want.out_key), 64'(got.out_key));
      field_eq("out_leave", want.out_leave, got.out_leave);
      field_eq("out_exchanged", want.out_exchanged, got.out_exchanged);
      field_eq("out_equity", 64'(want.out_equity), 64'(got.out_equity));
      field_eq("entry_valid", 64'(want.entry_valid), 64'(got.entry_valid));
      field_eq("heap_empty", 64'(want.heap_empty), 64'(got.heap_empty));
      field_eq("entry_count", 64'(want.entry_count), 64'(got.entry_count));
      field_eq("last_result", 64'(want.last_result), 64'(got.last_result));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  btk_chan_if #(.payload_t(in_beat_t))  in_ch ();
  btk_chan_if #(.payload_t(out_beat_t)) out_ch ();
  btk_chan_if #(.payload_t(limit_t))    cfg_ch ();

  bounded_top_k_min_heap uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  topk_heap_tracker sb = new();
  int burst_left = 0;
  int n_limit_writes = 0;

  always #6 clk = ~clk;

  initial begin
    #(12 * 600000);
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      sb.check_beat(out_ch.data);
    end
  end

  // result side: rotating stall pattern plus one long hold-off
  initial begin
    int cyc;
    int hold_left;
    bit hold_done;
    cyc = 0;
    hold_left = 0;
    hold_done = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (!hold_done && sb.n_cmd >= 40) begin
        hold_done = 1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case ((cyc / 64) % 4)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(3) != 0);
          2: out_ch.ready <= ($urandom_range(3) == 0);
          default: out_ch.ready <= cyc[1];
        endcase
      end
    end
  end

  function automatic in_beat_t mk(cmd_t c, logic [15:0] k, logic [63:0] lv,
                                  logic [63:0] ex, logic [31:0] eq);
    in_beat_t b;
    b.cmd = c;
    b.draw_key = k;
    b.leave_code = lv;
    b.exchanged_code = ex;
    b.equity_value = eq;
    return b;
  endfunction

  function automatic in_beat_t rand_beat(cmd_t c);
    in_beat_t b;
    int sel;
    sel = $urandom_range(9);
    b.cmd = c;
    if (sel < 5) b.draw_key = 16'($urandom);
    else if (sel < 8) b.draw_key = 16'($urandom_range(7));
    else if (sel == 8) b.draw_key = 16'($urandom_range(65535, 65528));
    else b.draw_key = '0;
    b.leave_code = {$urandom, $urandom};
    b.exchanged_code = ($urandom_range(3) == 0) ? 64'd0 : {$urandom, $urandom};
    b.equity_value = $urandom;
    return b;
  endfunction

  task automatic send_item(input in_beat_t b);
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.data <= b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.take_command(b);
  endtask

  task automatic issue(input in_beat_t b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    send_item(b);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.due_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_keep_limit(input limit_t v);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    sb.set_keep_limit(v);
    n_limit_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    in_beat_t dir_q[$];
    int ph_limit [0:7];
    int ph_items [0:7];
    int ph_ins [0:7];
    bit ph_flush [0:7];
    bit ph_drain [0:7];
    int lim;
    int r;
    cmd_t c;

    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;

    ph_limit = '{64, 1, 0, 12, 127, 5, 64, -1};
    ph_items = '{60, 25, 25, 40, 50, 35, 55, 20};
    ph_ins   = '{95, 60, 55, 70, 85, 60, 75, 65};
    ph_flush = '{0, 1, 1, 1, 0, 1, 1, 1};
    ph_drain = '{1, 0, 0, 0, 0, 0, 1, 1};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait_idle();
    write_keep_limit(limit_t'(64));

    dir_q.push_back(mk(CMD_POP, 16'h0000, '0, '0, '0));
    dir_q.push_back(mk(CMD_DRAIN, 16'hFFFF, '1, '1, '1));
    dir_q.push_back(mk(CMD_INSERT, 16'h0000, '0, '0, 32'h0000_0000));
    dir_q.push_back(mk(CMD_INSERT, 16'hFFFF, '1, '1, 32'h7FFF_FFFF));
    dir_q.push_back(mk(CMD_INSERT, 16'hFFFF, 64'h5555_5555_5555_5555,
                       64'hAAAA_AAAA_AAAA_AAAA, 32'h8000_0000));
    dir_q.push_back(mk(CMD_INSERT, 16'd100, 64'h0123_4567_89AB_CDEF, '0, 32'hFFFF_0000));
    dir_q.push_back(mk(CMD_INSERT, 16'd100, 64'hFEDC_BA98_7654_3210,
                       64'h1111_2222_3333_4444, 32'h0001_8000));
    dir_q.push_back(mk(CMD_INSERT, 16'h0000, 64'hDEAD_BEEF_0000_0001, '0, 32'hFFFF_FFFF));
    dir_q.push_back(mk(CMD_INSERT, 16'd7, 64'h8000_0000_0000_0000,
                       64'h0000_0000_0000_0001, 32'h0000_0001));
    dir_q.push_back(mk(CMD_POP, '0, '0, '0, '0));
    dir_q.push_back(mk(CMD_POP, '0, '0, '0, '0));
    dir_q.push_back(mk(CMD_DRAIN, '0, '0, '0, '0));
    dir_q.push_back(mk(CMD_POP, '0, '0, '0, '0));
    dir_q.push_back(mk(CMD_INSERT, 16'd3, 64'hA5A5_A5A5_5A5A_5A5A, '1, 32'h1234_5678));
    dir_q.push_back(mk(CMD_INSERT, 16'd9, 64'h0F0F_0F0F_F0F0_F0F0, '0, 32'hEDCB_A988));
    dir_q.push_back(mk(CMD_CLEAR, 16'hFFFF, '1, '1, '1));
    dir_q.push_back(mk(CMD_POP, '0, '0, '0, '0));
    dir_q.push_back(mk(CMD_DRAIN, '0, '0, '0, '0));
    dir_q.push_back(mk(CMD_INSERT, 16'd42, 64'hCAFE_F00D_0000_FFFF, '0, 32'h0000_FFFF));
    foreach (dir_q[i]) send_item(dir_q[i]);

    for (int p = 0; p < 8; p++) begin
      wait_idle();
      lim = (ph_limit[p] < 0) ? $urandom_range(1, 64) : ph_limit[p];
      write_keep_limit(limit_t'(lim));
      for (int k = 0; k < ph_items[p]; k++) begin
        r = $urandom_range(99);
        if (r < ph_ins[p]) begin
          c = CMD_INSERT;
        end else begin
          r = $urandom_range(9);
          if (r < 6 || !ph_flush[p]) c = CMD_POP;
          else if (r < 8) c = CMD_DRAIN;
          else c = CMD_CLEAR;
        end
        issue(rand_beat(c));
      end
      if (ph_drain[p]) issue(rand_beat(CMD_DRAIN));
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (sb.due_beats.size() != 0) begin
      $error("%0d expected result beats never arrived", sb.due_beats.size());
      sb.errors++;
    end
    $display("Ran %0d commands: %0d inserts (%0d evictions), %0d pops, %0d clears, %0d drains",
             sb.n_cmd, sb.n_insert, sb.n_evict, sb.n_pop, sb.n_clear, sb.n_drain);
    $display("%0d result beats checked, %0d empty hits, peak fill %0d,",
             sb.beats_ok, sb.n_empty, sb.peak_fill);
    $display("longest drain %0d, %0d limit writes", sb.deepest, n_limit_writes);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/btk_pkg.sv
rtl/btk_chan_if.sv
rtl/btk_ram.sv
rtl/btk_cmp.sv
rtl/bounded_top_k_min_heap.sv
sim/bounded_top_k_min_heap_tb.sv
